[design/lsb_pkg.sv]
// Package for the line and square blitter.
// Holds the command beat type, status type, register and figure codes.
// No dependencies.
`default_nettype none

package lsb_pkg;

	localparam int FRAME_PIXELS = 65536;
	localparam int ADDR_W       = $clog2(FRAME_PIXELS);
	localparam int COLOR_W      = 4;
	localparam int LEN_W        = 9;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

	localparam logic [2:0] REG_Y    = 3'd0;
	localparam logic [2:0] REG_X    = 3'd1;
	localparam logic [2:0] REG_LEN  = 3'd2;
	localparam logic [2:0] REG_MODE = 3'd3;

	localparam logic [1:0] FIG_SQUARE = 2'd0;
	localparam logic [1:0] FIG_VERT   = 2'd1;
	localparam logic [1:0] FIG_HORIZ  = 2'd2;
	localparam logic [1:0] FIG_DIAG   = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic               is_read;
		logic [ADDR_W-1:0]  addr;
		logic [ADDR_W-1:0]  inner_step;
		logic [LEN_W-1:0]   inner_len;
		logic [LEN_W-1:0]   outer_len;
		logic [COLOR_W-1:0] color;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

`default_nettype wire

[design/lsb_req_if.sv]
// Request channel of the blitter: valid, ready and one input beat.
// No dependencies.
`default_nettype none

interface lsb_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [2:0] reg_index;
	logic [7:0] reg_data;
	logic [7:0] read_row;
	logic [7:0] read_col;

	modport source (output valid, op, reg_index, reg_data, read_row, read_col, input ready);
	modport sink (input valid, op, reg_index, reg_data, read_row, read_col, output ready);
endinterface

`default_nettype wire

[design/lsb_rsp_if.sv]
// Response channel of the blitter: valid, ready and one pixel color beat.
// No dependencies.
`default_nettype none

interface lsb_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] pixel_color;

	modport source (output valid, pixel_color, input ready);
	modport sink (input valid, pixel_color, output ready);
endinterface

`default_nettype wire

[design/lsb_front.sv]
// Front end: accepts request beats, holds the drawing registers and turns
// each read or draw into a command for the queue. Uses lsb_pkg, lsb_req_if.
`default_nettype none

module lsb_front (
	input  wire                  clk,
	input  wire                  arst_n,
	lsb_req_if.sink              req,
	input  lsb_pkg::back_status_t status,
	input  wire                  fifo_full,
	output logic                 push,
	output lsb_pkg::cmd_t        push_cmd
);

	logic [7:0]         start_y_q;
	logic [7:0]         start_x_q;
	logic [7:0]         mode_q;
	logic               accept;
	logic [8:0]         n;
	logic [7:0]         half;
	logic [8:0]         side;
	logic [15:0]        row_step;
	logic [15:0]        col_step;
	lsb_pkg::cmd_t      draw_cmd;

	assign req.ready = !status.clearing && !fifo_full;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_y_q <= '0;
			start_x_q <= '0;
			mode_q    <= '0;
		end else if (accept && req.op == lsb_pkg::OP_WRITE) begin
			unique case (req.reg_index)
				lsb_pkg::REG_Y:    start_y_q <= req.reg_data;
				lsb_pkg::REG_X:    start_x_q <= req.reg_data;
				lsb_pkg::REG_MODE: mode_q    <= req.reg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		n        = (req.reg_data == 8'd0) ? 9'd256 : {1'b0, req.reg_data};
		half     = n[8:1];
		side     = {n[8:1], 1'b0};
		row_step = mode_q[4] ? 16'hff00 : 16'h0100;
		col_step = mode_q[5] ? 16'hffff : 16'h0001;

		draw_cmd            = '0;
		draw_cmd.is_read    = 1'b0;
		draw_cmd.color      = mode_q[3:0];
		draw_cmd.addr       = {start_y_q, start_x_q};
		draw_cmd.inner_len  = n;
		draw_cmd.outer_len  = 9'd1;
		draw_cmd.inner_step = col_step;
		unique case (mode_q[7:6])
			lsb_pkg::FIG_SQUARE: begin
				draw_cmd.addr       = {start_y_q, start_x_q} - {half, half};
				draw_cmd.inner_step = 16'h0100;
				draw_cmd.inner_len  = side;
				draw_cmd.outer_len  = side;
			end
			lsb_pkg::FIG_VERT:  draw_cmd.inner_step = row_step;
			lsb_pkg::FIG_HORIZ: draw_cmd.inner_step = col_step;
			lsb_pkg::FIG_DIAG:  draw_cmd.inner_step = row_step + col_step;
			default: begin
			end
		endcase
	end

	always_comb begin
		push     = 1'b0;
		push_cmd = draw_cmd;
		if (accept) begin
			if (req.op == lsb_pkg::OP_READ) begin
				push              = 1'b1;
				push_cmd          = '0;
				push_cmd.is_read  = 1'b1;
				push_cmd.addr     = {req.read_row, req.read_col};
			end else if (req.reg_index == lsb_pkg::REG_LEN) begin
				push = (draw_cmd.inner_len != '0);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) req.ready |-> !status.clearing)
		else $error("front ready during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !fifo_full)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !push_cmd.is_read) |-> (push_cmd.inner_len != '0 && push_cmd.outer_len != '0))
		else $error("empty draw command queued");

endmodule

`default_nettype wire

[design/lsb_cmd_fifo.sv]
// Short command queue between the front end and the drawing engine.
// Uses lsb_pkg.
`default_nettype none

module lsb_cmd_fifo (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  lsb_pkg::cmd_t  push_cmd,
	output logic           full,
	input  wire            pop,
	output lsb_pkg::cmd_t  head,
	output logic           empty
);

	lsb_pkg::cmd_t                    slot_q [lsb_pkg::FIFO_DEPTH];
	logic [lsb_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [lsb_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [lsb_pkg::FIFO_PTR_W:0]     count_q;

	assign full  = (count_q == (lsb_pkg::FIFO_PTR_W+1)'(lsb_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (lsb_pkg::FIFO_PTR_W+1)'(lsb_pkg::FIFO_DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow push");

endmodule

`default_nettype wire

[design/lsb_back.sv]
// Drawing engine: clears the frame store after reset, runs draw commands
// one pixel per cycle and serves pixel reads. Uses lsb_pkg, lsb_rsp_if.
`default_nettype none

module lsb_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lsb_pkg::cmd_t         head,
	input  wire                   empty,
	output logic                  pop,
	output lsb_pkg::back_status_t status,
	lsb_rsp_if.source             rsp
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_DRAW  = 2'd2;

	logic [lsb_pkg::COLOR_W-1:0] mem [lsb_pkg::FRAME_PIXELS];

	logic [1:0]                  state_q;
	logic [lsb_pkg::ADDR_W-1:0]  addr_q;
	logic [lsb_pkg::ADDR_W-1:0]  col_addr_q;
	logic [lsb_pkg::ADDR_W-1:0]  step_q;
	logic [lsb_pkg::LEN_W-1:0]   inner_cnt_q;
	logic [lsb_pkg::LEN_W-1:0]   inner_len_q;
	logic [lsb_pkg::LEN_W-1:0]   outer_cnt_q;
	logic [lsb_pkg::COLOR_W-1:0] color_q;
	logic                        rd_pend_s1;
	logic [lsb_pkg::COLOR_W-1:0] rd_data_s1;
	logic                        out_v_q;
	logic [lsb_pkg::COLOR_W-1:0] out_pix_q;
	logic                        rd_issue;
	logic                        we;
	logic [lsb_pkg::COLOR_W-1:0] wdata;
	logic                        out_free;

	assign status.clearing = (state_q == ST_CLEAR);
	assign rsp.valid       = out_v_q;
	assign rsp.pixel_color = out_pix_q;
	assign out_free        = !out_v_q || rsp.ready;
	assign we              = (state_q == ST_CLEAR) || (state_q == ST_DRAW);
	assign wdata           = (state_q == ST_DRAW) ? color_q : '0;

	always_comb begin
		pop      = 1'b0;
		rd_issue = 1'b0;
		if (state_q == ST_IDLE && !empty) begin
			if (head.is_read) begin
				if (!rd_pend_s1 && out_free) begin
					pop      = 1'b1;
					rd_issue = 1'b1;
				end
			end else begin
				pop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_q] <= wdata;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[head.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_pix_q <= rd_data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_issue;
			if (rd_pend_s1) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			col_addr_q  <= '0;
			step_q      <= '0;
			inner_cnt_q <= '0;
			inner_len_q <= '0;
			outer_cnt_q <= '0;
			color_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop && !head.is_read) begin
						addr_q      <= head.addr;
						col_addr_q  <= head.addr;
						step_q      <= head.inner_step;
						inner_cnt_q <= head.inner_len;
						inner_len_q <= head.inner_len;
						outer_cnt_q <= head.outer_len;
						color_q     <= head.color;
						state_q     <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (inner_cnt_q == 9'd1) begin
						if (outer_cnt_q == 9'd1) begin
							state_q <= ST_IDLE;
						end else begin
							outer_cnt_q <= outer_cnt_q - 1'b1;
							col_addr_q  <= col_addr_q + 1'b1;
							addr_q      <= col_addr_q + 1'b1;
							inner_cnt_q <= inner_len_q;
						end
					end else begin
						inner_cnt_q <= inner_cnt_q - 1'b1;
						addr_q      <= addr_q + step_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) rd_pend_s1 |=> out_v_q)
		else $error("read data lost before output register");
	assert property (@(posedge clk) disable iff (!arst_n) rd_issue |-> (!rd_pend_s1 && out_free))
		else $error("read issued without a free output slot");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_CLEAR) |-> !pop)
		else $error("command taken during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> (inner_cnt_q != '0 && outer_cnt_q != '0))
		else $error("draw counters reached zero");

endmodule

`default_nettype wire

[design/line_and_square_blitter.sv]
// Top level of the line and square blitter: front end, command queue and
// drawing engine. Uses lsb_pkg, lsb_req_if, lsb_rsp_if and the submodules.
// A register write other than length only updates the front end; a length
// write queues a draw, which the drawing engine runs through its single
// frame store port, painting one pixel per cycle. A pixel read passes
// through the command queue, the frame store read register and the output
// register before its beat is offered; a new read is not issued while the
// previous one is still in the read register. While the engine clears
// all 65536 pixels after reset, one per cycle, requests are not ready.
`default_nettype none

module line_and_square_blitter (
	input  wire       clk,
	input  wire       arst_n,
	lsb_req_if.sink   req,
	lsb_rsp_if.source rsp
);

	lsb_pkg::back_status_t status;
	lsb_pkg::cmd_t         push_cmd;
	lsb_pkg::cmd_t         head;
	logic                  push;
	logic                  pop;
	logic                  full;
	logic                  empty;

	lsb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.status   (status),
		.fifo_full(full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lsb_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	lsb_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.status(status),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire
